### rtl/core/sird_pkg.sv
package sird_pkg;

    localparam int MAX_RADIX  = 16;
    localparam int MAX_DIGITS = 32;

    localparam int DIGIT_W = 4;
    localparam int COUNT_W = $clog2(MAX_DIGITS) + 1;
    localparam int ADDR_W  = $clog2(MAX_DIGITS);
    localparam int MAG_W   = 32;

    localparam logic [7:0] SYM_MIN   = 8'd33;
    localparam logic [7:0] SYM_MAX   = 8'd126;
    localparam logic [7:0] SYM_PLUS  = 8'd43;
    localparam logic [7:0] SYM_MINUS = 8'd45;

    // configuration register indexes
    localparam logic [1:0] REG_RADIX  = 2'd0;
    localparam logic [1:0] REG_SYM_LO = 2'd1;
    localparam logic [1:0] REG_SYM_HI = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_SIGN,
        ST_READ,
        ST_LOAD
    } t_state;

    // divider result, valid in the cycle done is high
    typedef struct packed {
        logic               done;
        logic [MAG_W-1:0]   quot;
        logic [DIGIT_W-1:0] rem;
    } t_div_res;

    function automatic logic [7:0] symbol_of(input logic [63:0] lo, input logic [63:0] hi,
                                             input logic [3:0] d);
        logic [5:0] sh;
        sh = {d[2:0], 3'b000};
        if (d[3]) begin
            return hi[sh +: 8];
        end
        return lo[sh +: 8];
    endfunction

endpackage

### rtl/core/signed_integer_to_radix_digits.sv
// Converts a signed 32-bit value to text in a configured radix (2 to 16) and
// sends it one character per output transfer, most significant digit first,
// with o_last on the final character. Negative values start with '-'. The
// digit alphabet lives in r_sym_lo / r_sym_hi, one byte per digit; if
// the radix is below two or above 16, or a symbol in use is outside 33..126,
// is '+' or '-', or repeats, the value is swallowed with no output. One value
// at a time: o_stall is high from the cycle after the input transfer until
// the last character is in the output register or the value is swallowed. Per
// value, the block takes it, checks the alphabet symbols in use one by one,
// runs the shared bit-serial divider once per digit (one quotient bit per
// cycle), then reads the digit memory back in reverse and loads the output
// register, after a minus sign for a negative value; output stalls hold the
// readout. Configuration must only be written while the block is idle.
module signed_integer_to_radix_digits (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_value,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_character,
    output logic        o_last
);

    // configuration registers
    logic [4:0]  r_radix;
    logic [63:0] r_sym_lo;
    logic [63:0] r_sym_hi;

    // sequencer
    sird_pkg::t_state r_state, n_state;
    logic [3:0]                   r_idx, n_idx;
    logic                         r_neg, n_neg;
    logic [sird_pkg::MAG_W-1:0]   r_mag, n_mag;
    logic [sird_pkg::COUNT_W-1:0] r_count, n_count;

    // output register
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_char, n_char;
    logic       r_last, n_last;
    logic       slot_free;

    // digit memory
    logic [sird_pkg::DIGIT_W-1:0] r_mem [sird_pkg::MAX_DIGITS];
    logic [sird_pkg::DIGIT_W-1:0] r_rd_data;
    logic                         mem_we;
    logic [sird_pkg::ADDR_W-1:0]  wr_addr;
    logic [sird_pkg::ADDR_W-1:0]  rd_addr;

    // shared units
    logic                       div_start;
    logic [sird_pkg::MAG_W-1:0] div_dividend;
    sird_pkg::t_div_res         div_res;
    logic                       sym_bad;
    logic                       radix_bad;

    sird_alpha_check u_alpha_check (
        .i_sym_lo (r_sym_lo),
        .i_sym_hi (r_sym_hi),
        .i_radix  (r_radix),
        .i_idx    (r_idx),
        .o_bad    (sym_bad)
    );

    sird_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_radix),
        .o_res      (div_res)
    );

    // configuration writes, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= '0;
            r_sym_lo <= '0;
            r_sym_hi <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sird_pkg::REG_RADIX:  r_radix  <= i_cfg_data[4:0];
                sird_pkg::REG_SYM_LO: r_sym_lo <= i_cfg_data;
                sird_pkg::REG_SYM_HI: r_sym_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign radix_bad = (r_radix < 5'd2) || (r_radix > 5'(sird_pkg::MAX_RADIX));
    assign slot_free = !r_out_valid || !i_stall;
    assign wr_addr   = r_count[sird_pkg::ADDR_W-1:0];
    assign rd_addr   = 5'(r_count - 6'd1);

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_neg        = r_neg;
        n_mag        = r_mag;
        n_count      = r_count;
        n_out_valid  = r_out_valid && i_stall;
        n_char       = r_char;
        n_last       = r_last;
        div_start    = 1'b0;
        div_dividend = r_mag;
        mem_we       = 1'b0;
        case (r_state)
            sird_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_neg   = i_value[31];
                    n_mag   = i_value[31] ? (32'd0 - i_value) : i_value;
                    n_idx   = '0;
                    n_state = sird_pkg::ST_CHECK;
                end
            end
            sird_pkg::ST_CHECK: begin
                // one alphabet symbol per cycle
                if (radix_bad || sym_bad) begin
                    n_state = sird_pkg::ST_IDLE;
                end else if ({1'b0, r_idx} == r_radix - 5'd1) begin
                    n_count   = '0;
                    div_start = 1'b1;
                    n_state   = sird_pkg::ST_DIVIDE;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            sird_pkg::ST_DIVIDE: begin
                if (div_res.done) begin
                    mem_we  = 1'b1;
                    n_count = r_count + 6'd1;
                    n_mag   = div_res.quot;
                    if (div_res.quot == '0 ||
                        r_count == 6'(sird_pkg::MAX_DIGITS - 1)) begin
                        n_state = r_neg ? sird_pkg::ST_SIGN : sird_pkg::ST_READ;
                    end else begin
                        // next digit from the fresh quotient
                        div_dividend = div_res.quot;
                        div_start    = 1'b1;
                    end
                end
            end
            sird_pkg::ST_SIGN: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_char      = sird_pkg::SYM_MINUS;
                    n_last      = 1'b0;
                    n_state     = sird_pkg::ST_READ;
                end
            end
            sird_pkg::ST_READ: begin
                // memory read address presented this cycle
                n_state = sird_pkg::ST_LOAD;
            end
            sird_pkg::ST_LOAD: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_char      = sird_pkg::symbol_of(r_sym_lo, r_sym_hi, r_rd_data);
                    n_last      = (r_count == 6'd1);
                    n_count     = r_count - 6'd1;
                    n_state     = (r_count == 6'd1) ? sird_pkg::ST_IDLE : sird_pkg::ST_READ;
                end
            end
            default: begin
                n_state = sird_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sird_pkg::ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_neg       <= 1'b0;
            r_mag       <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            r_neg       <= n_neg;
            r_mag       <= n_mag;
        end
        r_char <= n_char;
        r_last <= n_last;
    end

    // digit memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= div_res.rem;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_stall     = (r_state != sird_pkg::ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

endmodule

### rtl/core/sird_divider.sv
// restoring divider, one quotient bit per cycle
module sird_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [sird_pkg::MAG_W-1:0] i_dividend,
    input  logic [4:0]                 i_divisor,
    output sird_pkg::t_div_res         o_res
);

    logic [sird_pkg::MAG_W-1:0]   r_quot, n_quot;
    logic [sird_pkg::DIGIT_W-1:0] r_rem, n_rem;
    logic [4:0]                   r_cnt, n_cnt;
    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    logic [4:0]                   trial;
    logic                         fits;

    always_comb begin
        trial  = {r_rem, r_quot[sird_pkg::MAG_W-1]};
        fits   = trial >= i_divisor;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_quot = i_dividend;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_quot = {r_quot[sird_pkg::MAG_W-2:0], fits};
            n_rem  = fits ? 4'(trial - i_divisor) : trial[3:0];
            n_cnt  = r_cnt + 5'd1;
            if (r_cnt == 5'(sird_pkg::MAG_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;
    assign o_res.rem  = r_rem;

endmodule

### rtl/core/sird_alpha_check.sv
// flags symbol idx as unusable: out of range, a sign, or repeated later in the alphabet
module sird_alpha_check (
    input  logic [63:0] i_sym_lo,
    input  logic [63:0] i_sym_hi,
    input  logic [4:0]  i_radix,
    input  logic [3:0]  i_idx,
    output logic        o_bad
);

    logic [7:0] sym;

    always_comb begin
        sym   = sird_pkg::symbol_of(i_sym_lo, i_sym_hi, i_idx);
        o_bad = (sym < sird_pkg::SYM_MIN) || (sym > sird_pkg::SYM_MAX) ||
                (sym == sird_pkg::SYM_PLUS) || (sym == sird_pkg::SYM_MINUS);
        for (int j = 0; j < 16; j++) begin
            if ((4'(j) > i_idx) && (5'(j) < i_radix) &&
                (sird_pkg::symbol_of(i_sym_lo, i_sym_hi, 4'(j)) == sym)) begin
                o_bad = 1'b1;
            end
        end
    end

endmodule

### rtl/core/sird_checker.sv
module sird_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_character,
    input logic       o_last
);

    // a stalled output transfer stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output valid dropped while stalled");

    // one value at a time: busy right after taking an input
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken while previous value in progress");

    // only characters in 33..126 other than '+' (alphabet symbols or the minus sign) come out
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_character >= 8'd33) && (o_character <= 8'd126) &&
                    (o_character != 8'd43))
        else $error("character outside the allowed symbol range");

    // a minus sign is always followed by digits
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_character == 8'd45) |-> !o_last)
        else $error("minus sign flagged as last character");

endmodule

bind signed_integer_to_radix_digits sird_checker u_sird_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_character (o_character),
    .o_last      (o_last)
);
